// File: sv/segment_intersection_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection classifier.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CLASSIFIER_ASSERT_SVH
`define SEGMENT_INTERSECTION_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The expression must hold at every clock edge outside reset.
`define SIC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

// File: sv/sic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and constants of the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

   // Configuration register widths.
   localparam int TOL_W      = 23;
   localparam int FLOOR_W    = 16;
   localparam int CSR_DATA_W = 23;

   // Register stages of the front end and of the classification back end.
   localparam int FRONT_STAGES = 5;
   localparam int CLASS_STAGES = 3;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_TOLERANCE   = 1'b0,
      CSR_SCALE_FLOOR = 1'b1
   } csr_idx_type;

   // Result of one tolerant orientation test.
   typedef enum logic [1:0] {
      ORI_COL = 2'd0,
      ORI_CCW = 2'd1,
      ORI_CW  = 2'd2
   } ori_type;

   // Result class of a transaction.
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_PROPER  = 2'd1,
      KIND_TOUCH   = 2'd2,
      KIND_OVERLAP = 2'd3
   } kind_type;

   // Box and degenerate-segment tests, computed early and carried along.
   typedef struct packed {
      logic inbox_a3;   // second start inside the tolerant box of the first
      logic inbox_a4;   // second end inside the tolerant box of the first
      logic inbox_b1;   // first start inside the tolerant box of the second
      logic inbox_b2;   // first end inside the tolerant box of the second
      logic near_a;     // first segment is degenerate
      logic near_b;     // second segment is degenerate
      logic overlap;    // tolerant boxes overlap in x and y
   } box_flags_type;

endpackage

// File: sv/sic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_front
// Front end: differences, products, box tests, cross products and scale sums.
// ----------------------------------------------------------------------------
module sic_front import sic_pkg::*; #(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS  = 8,
   parameter int SCALE_W    = 52,
   parameter int DET_W      = 51
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [7:0][COORD_BITS-1:0]      in_coord,
   input  logic [TOL_W-1:0]                tolerance,
   input  logic [FLOOR_W-1:0]              scale_floor,
   output logic                            out_valid,
   output logic [3:0][DET_W-1:0]           out_det,
   output logic [3:0][SCALE_W-1:0]         out_scale,
   output box_flags_type                   out_flags
);

   localparam int D_W    = COORD_BITS + 1;
   localparam int PROD_W = 2 * D_W;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int Q_W    = SQ_W + 1;
   localparam int BOX_W  = ((COORD_BITS > TOL_W) ? COORD_BITS : TOL_W) + 2;
   localparam int FL_SHL = (2 * FRAC_BITS >= FLOOR_W) ? 2 * FRAC_BITS - FLOOR_W : 0;
   localparam int FL_SHR = (2 * FRAC_BITS < FLOOR_W) ? FLOOR_W - 2 * FRAC_BITS : 0;

   // Stage 1: input register.
   logic                         vld1_ff;
   logic signed [COORD_BITS-1:0] crd_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         crd_ff[k] <= in_coord[k];
      end
   end

   // Stage 2: coordinate differences and tolerant boxes of both segments.
   logic signed [D_W-1:0]   px [4];
   logic signed [D_W-1:0]   py [4];
   logic signed [BOX_W-1:0] bx [4];
   logic signed [BOX_W-1:0] by [4];
   logic signed [BOX_W-1:0] tol_box;
   logic signed [D_W-1:0]   dx_in [6];
   logic signed [D_W-1:0]   dy_in [6];
   logic signed [BOX_W-1:0] mnx_in [2];
   logic signed [BOX_W-1:0] mny_in [2];
   logic signed [BOX_W-1:0] mxx [2];
   logic signed [BOX_W-1:0] mxy [2];
   logic signed [BOX_W-1:0] lox_in [2];
   logic signed [BOX_W-1:0] hix_in [2];
   logic signed [BOX_W-1:0] loy_in [2];
   logic signed [BOX_W-1:0] hiy_in [2];

   assign tol_box = {{(BOX_W - TOL_W){1'b0}}, tolerance};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px[k] = {crd_ff[2*k][COORD_BITS-1], crd_ff[2*k]};
         py[k] = {crd_ff[2*k+1][COORD_BITS-1], crd_ff[2*k+1]};
         bx[k] = {{(BOX_W - COORD_BITS){crd_ff[2*k][COORD_BITS-1]}}, crd_ff[2*k]};
         by[k] = {{(BOX_W - COORD_BITS){crd_ff[2*k+1][COORD_BITS-1]}}, crd_ff[2*k+1]};
      end
      // Pairs: 1-2, 1-3, 1-4, 3-4, 2-3, 2-4, each as later minus earlier point.
      dx_in[0] = px[1] - px[0];   dy_in[0] = py[1] - py[0];
      dx_in[1] = px[2] - px[0];   dy_in[1] = py[2] - py[0];
      dx_in[2] = px[3] - px[0];   dy_in[2] = py[3] - py[0];
      dx_in[3] = px[3] - px[2];   dy_in[3] = py[3] - py[2];
      dx_in[4] = px[2] - px[1];   dy_in[4] = py[2] - py[1];
      dx_in[5] = px[3] - px[1];   dy_in[5] = py[3] - py[1];
      for (int s = 0; s < 2; s++) begin
         mnx_in[s] = (bx[2*s] < bx[2*s+1]) ? bx[2*s] : bx[2*s+1];
         mxx[s]    = (bx[2*s] > bx[2*s+1]) ? bx[2*s] : bx[2*s+1];
         mny_in[s] = (by[2*s] < by[2*s+1]) ? by[2*s] : by[2*s+1];
         mxy[s]    = (by[2*s] > by[2*s+1]) ? by[2*s] : by[2*s+1];
         lox_in[s] = mnx_in[s] - tol_box;
         hix_in[s] = mxx[s] + tol_box;
         loy_in[s] = mny_in[s] - tol_box;
         hiy_in[s] = mxy[s] + tol_box;
      end
   end

   logic                    vld2_ff;
   logic signed [D_W-1:0]   dx_ff [6];
   logic signed [D_W-1:0]   dy_ff [6];
   logic signed [BOX_W-1:0] mnx_ff [2];
   logic signed [BOX_W-1:0] mny_ff [2];
   logic signed [BOX_W-1:0] lox_ff [2];
   logic signed [BOX_W-1:0] hix_ff [2];
   logic signed [BOX_W-1:0] loy_ff [2];
   logic signed [BOX_W-1:0] hiy_ff [2];
   logic signed [BOX_W-1:0] bx_ff [4];
   logic signed [BOX_W-1:0] by_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) begin
         dx_ff[k] <= dx_in[k];
         dy_ff[k] <= dy_in[k];
      end
      for (int s = 0; s < 2; s++) begin
         mnx_ff[s] <= mnx_in[s];
         mny_ff[s] <= mny_in[s];
         lox_ff[s] <= lox_in[s];
         hix_ff[s] <= hix_in[s];
         loy_ff[s] <= loy_in[s];
         hiy_ff[s] <= hiy_in[s];
      end
      for (int k = 0; k < 4; k++) begin
         bx_ff[k] <= bx[k];
         by_ff[k] <= by[k];
      end
   end

   // Stage 3: cross product terms, squared differences and box flags.
   logic signed [PROD_W-1:0] pa_in [4];
   logic signed [PROD_W-1:0] pb_in [4];
   logic signed [PROD_W-1:0] sqx_full [6];
   logic signed [PROD_W-1:0] sqy_full [6];
   logic signed [BOX_W-1:0]  nx [2];
   logic signed [BOX_W-1:0]  ny [2];
   box_flags_type            flags_in;

   always_comb begin
      // First test: (p2-p1) x (p3-p1); second: (p2-p1) x (p4-p1).
      pa_in[0] = dx_ff[0] * dy_ff[1];   pb_in[0] = dy_ff[0] * dx_ff[1];
      pa_in[1] = dx_ff[0] * dy_ff[2];   pb_in[1] = dy_ff[0] * dx_ff[2];
      // Third: (p4-p3) x (p1-p3); fourth: (p4-p3) x (p2-p3).
      pa_in[2] = dy_ff[3] * dx_ff[1];   pb_in[2] = dx_ff[3] * dy_ff[1];
      pa_in[3] = dy_ff[3] * dx_ff[4];   pb_in[3] = dx_ff[3] * dy_ff[4];
      for (int k = 0; k < 6; k++) begin
         sqx_full[k] = dx_ff[k] * dx_ff[k];
         sqy_full[k] = dy_ff[k] * dy_ff[k];
      end
      nx[0] = {{(BOX_W - D_W){dx_ff[0][D_W-1]}}, dx_ff[0]};
      ny[0] = {{(BOX_W - D_W){dy_ff[0][D_W-1]}}, dy_ff[0]};
      nx[1] = {{(BOX_W - D_W){dx_ff[3][D_W-1]}}, dx_ff[3]};
      ny[1] = {{(BOX_W - D_W){dy_ff[3][D_W-1]}}, dy_ff[3]};
      flags_in.inbox_a3 = bx_ff[2] >= lox_ff[0] && bx_ff[2] <= hix_ff[0] &&
                          by_ff[2] >= loy_ff[0] && by_ff[2] <= hiy_ff[0];
      flags_in.inbox_a4 = bx_ff[3] >= lox_ff[0] && bx_ff[3] <= hix_ff[0] &&
                          by_ff[3] >= loy_ff[0] && by_ff[3] <= hiy_ff[0];
      flags_in.inbox_b1 = bx_ff[0] >= lox_ff[1] && bx_ff[0] <= hix_ff[1] &&
                          by_ff[0] >= loy_ff[1] && by_ff[0] <= hiy_ff[1];
      flags_in.inbox_b2 = bx_ff[1] >= lox_ff[1] && bx_ff[1] <= hix_ff[1] &&
                          by_ff[1] >= loy_ff[1] && by_ff[1] <= hiy_ff[1];
      flags_in.near_a   = nx[0] <= tol_box && nx[0] >= -tol_box &&
                          ny[0] <= tol_box && ny[0] >= -tol_box;
      flags_in.near_b   = nx[1] <= tol_box && nx[1] >= -tol_box &&
                          ny[1] <= tol_box && ny[1] >= -tol_box;
      flags_in.overlap  = mnx_ff[0] <= hix_ff[1] && mnx_ff[1] <= hix_ff[0] &&
                          mny_ff[0] <= hiy_ff[1] && mny_ff[1] <= hiy_ff[0];
   end

   logic                     vld3_ff;
   logic signed [PROD_W-1:0] pa_ff [4];
   logic signed [PROD_W-1:0] pb_ff [4];
   logic [SQ_W-1:0]          sqx_ff [6];
   logic [SQ_W-1:0]          sqy_ff [6];
   box_flags_type            flags3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pa_ff[k] <= pa_in[k];
         pb_ff[k] <= pb_in[k];
      end
      for (int k = 0; k < 6; k++) begin
         sqx_ff[k] <= sqx_full[k][SQ_W-1:0];
         sqy_ff[k] <= sqy_full[k][SQ_W-1:0];
      end
      flags3_ff <= flags_in;
   end

   // Stage 4: cross products and squared pair lengths.
   logic [DET_W-1:0] det_in [4];
   logic [Q_W-1:0]   q_in [6];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         det_in[k] = {{(DET_W - PROD_W){pa_ff[k][PROD_W-1]}}, pa_ff[k]} -
                     {{(DET_W - PROD_W){pb_ff[k][PROD_W-1]}}, pb_ff[k]};
      end
      for (int k = 0; k < 6; k++) begin
         q_in[k] = {1'b0, sqx_ff[k]} + {1'b0, sqy_ff[k]};
      end
   end

   logic             vld4_ff;
   logic [DET_W-1:0] det4_ff [4];
   logic [Q_W-1:0]   q_ff [6];
   box_flags_type    flags4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         det4_ff[k] <= det_in[k];
      end
      for (int k = 0; k < 6; k++) begin
         q_ff[k] <= q_in[k];
      end
      flags4_ff <= flags3_ff;
   end

   // Stage 5: scale sum of each test, with the aligned floor added.
   logic [SCALE_W-1:0] floor_al;
   logic [SCALE_W-1:0] qs [6];
   logic [SCALE_W-1:0] scale_in [4];

   assign floor_al = ({{(SCALE_W - FLOOR_W){1'b0}}, scale_floor} << FL_SHL) >> FL_SHR;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         qs[k] = {{(SCALE_W - Q_W){1'b0}}, q_ff[k]};
      end
      scale_in[0] = qs[0] + qs[4] + qs[1] + floor_al;
      scale_in[1] = qs[0] + qs[5] + qs[2] + floor_al;
      scale_in[2] = qs[3] + qs[2] + qs[1] + floor_al;
      scale_in[3] = qs[3] + qs[5] + qs[4] + floor_al;
   end

   logic               vld5_ff;
   logic [DET_W-1:0]   det5_ff [4];
   logic [SCALE_W-1:0] scale_ff [4];
   box_flags_type      flags5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else begin
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         det5_ff[k]  <= det4_ff[k];
         scale_ff[k] <= scale_in[k];
      end
      flags5_ff <= flags4_ff;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         out_det[k]   = det5_ff[k];
         out_scale[k] = scale_ff[k];
      end
   end

   assign out_valid = vld5_ff;
   assign out_flags = flags5_ff;

endmodule

// File: sv/sic_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module sic_isqrt import sic_pkg::*; #(
   parameter int VALUE_W = 52
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [VALUE_W-1:0]     value,
   output logic                   out_valid,
   output logic [VALUE_W/2-1:0]   root
);

   localparam int ROOT_W = VALUE_W / 2;

   logic [ROOT_W-1:0]  vld_ff;
   logic [VALUE_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      localparam int BIT = ROOT_W - 1 - i;

      logic               vld_prev;
      logic [VALUE_W-1:0] rem_prev;
      logic [ROOT_W-1:0]  root_prev;
      logic [VALUE_W-1:0] trial;
      logic [VALUE_W-1:0] rem_in;
      logic [ROOT_W-1:0]  root_in;

      if (i == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = value;
         assign root_prev = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      // Try setting this root bit: (R + 2^b)^2 - R^2 = 2^(b+1) R + 2^(2b).
      assign trial = ({{(VALUE_W - ROOT_W){1'b0}}, root_prev} << (BIT + 1)) |
                     ({{(VALUE_W - 1){1'b0}}, 1'b1} << (2 * BIT));

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | ({{(ROOT_W - 1){1'b0}}, 1'b1} << BIT);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];

endmodule

// File: sv/sic_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_classify
// Back end: thresholds, orientation tests and the final crossing class.
// ----------------------------------------------------------------------------
module sic_classify import sic_pkg::*; #(
   parameter int DET_W  = 51,
   parameter int ROOT_W = 26
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [3:0][DET_W-1:0]       in_det,
   input  logic [3:0][ROOT_W-1:0]      in_root,
   input  box_flags_type               in_flags,
   input  logic [TOL_W-1:0]            tolerance,
   output logic                        out_valid,
   output kind_type                    out_kind
);

   localparam int THR_W = TOL_W + ROOT_W;
   localparam int CMP_W = ((DET_W > THR_W + 1) ? DET_W : THR_W + 1) + 1;

   // Stage 1: threshold of each test.
   logic             vld1_ff;
   logic [THR_W-1:0] thr_ff [4];
   logic [DET_W-1:0] det1_ff [4];
   box_flags_type    flags1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         thr_ff[k]  <= tolerance * in_root[k];
         det1_ff[k] <= in_det[k];
      end
      flags1_ff <= in_flags;
   end

   // Stage 2: orientation of each test against its threshold.
   logic signed [CMP_W-1:0] det_x [4];
   logic signed [CMP_W-1:0] thr_x [4];
   ori_type                 ori_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         det_x[k] = {{(CMP_W - DET_W){det1_ff[k][DET_W-1]}}, det1_ff[k]};
         thr_x[k] = {{(CMP_W - THR_W){1'b0}}, thr_ff[k]};
         priority if (det_x[k] > thr_x[k]) begin
            ori_in[k] = ORI_CCW;
         end else if (det_x[k] < -thr_x[k]) begin
            ori_in[k] = ORI_CW;
         end else begin
            ori_in[k] = ORI_COL;
         end
      end
   end

   logic          vld2_ff;
   ori_type       ori_ff [4];
   box_flags_type flags2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         ori_ff[k] <= ori_in[k];
      end
      flags2_ff <= flags1_ff;
   end

   // Stage 3: crossing class from the four orientations and the box flags.
   logic     all_col;
   logic     any_col;
   logic     proper;
   kind_type kind_in;

   always_comb begin
      all_col = ori_ff[0] == ORI_COL && ori_ff[1] == ORI_COL &&
                ori_ff[2] == ORI_COL && ori_ff[3] == ORI_COL;
      any_col = ori_ff[0] == ORI_COL || ori_ff[1] == ORI_COL ||
                ori_ff[2] == ORI_COL || ori_ff[3] == ORI_COL;
      proper  = ori_ff[0] != ori_ff[1] && ori_ff[2] != ori_ff[3] && !any_col;
      priority if (proper) begin
         kind_in = KIND_PROPER;
      end else if (all_col) begin
         priority if (flags2_ff.near_a && flags2_ff.inbox_b1) begin
            kind_in = KIND_TOUCH;
         end else if (flags2_ff.near_b && flags2_ff.inbox_a3) begin
            kind_in = KIND_TOUCH;
         end else if (flags2_ff.near_a || flags2_ff.near_b) begin
            kind_in = KIND_NONE;
         end else if (flags2_ff.overlap) begin
            kind_in = KIND_OVERLAP;
         end else begin
            kind_in = KIND_NONE;
         end
      end else if ((ori_ff[0] == ORI_COL && flags2_ff.inbox_a3) ||
                   (ori_ff[1] == ORI_COL && flags2_ff.inbox_a4) ||
                   (ori_ff[2] == ORI_COL && flags2_ff.inbox_b1) ||
                   (ori_ff[3] == ORI_COL && flags2_ff.inbox_b2)) begin
         kind_in = KIND_TOUCH;
      end else begin
         kind_in = KIND_NONE;
      end
   end

   logic     vld3_ff;
   kind_type kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign out_valid = vld3_ff;
   assign out_kind  = kind_ff;

endmodule

// File: sv/segment_intersection_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_classifier
// Classifies a pair of 2D segments as none, crossing, touch or overlap.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   busy stays low: the pipeline takes a new pair of segments every cycle.
//   The eight coordinates are signed fixed point with FRAC_BITS fraction bits.
//   The result appears on rsp_crossing_kind with rsp_valid high for exactly
//   one cycle, in the order the pairs came in.
//   The pipeline is made of the five front stages (differences, products, sums),
//   the integer square root with one result bit per stage, and the three
//   back stages (threshold multiply, orientation compare, class decode).
//   The receiver cannot stall the result; nothing is held back.
//   Reset clears all pipeline valid bits and sets tolerance and scale_floor to 1.
//   The user must write the registers through csr_write_enable, csr_index and
//   csr_write_data only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module segment_intersection_classifier import sic_pkg::*; #(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]  req_first_start_x,
   input  logic signed [COORD_BITS-1:0]  req_first_start_y,
   input  logic signed [COORD_BITS-1:0]  req_first_end_x,
   input  logic signed [COORD_BITS-1:0]  req_first_end_y,
   input  logic signed [COORD_BITS-1:0]  req_second_start_x,
   input  logic signed [COORD_BITS-1:0]  req_second_start_y,
   input  logic signed [COORD_BITS-1:0]  req_second_end_x,
   input  logic signed [COORD_BITS-1:0]  req_second_end_y,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_crossing_kind,
   input  logic                          csr_write_enable,
   input  logic [0:0]                    csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_write_data
);

`include "segment_intersection_classifier_assert.svh"

   localparam int SCALE_W  = (2 * COORD_BITS + 4 > 34) ? 2 * COORD_BITS + 4 : 34;
   localparam int ROOT_W   = SCALE_W / 2;
   localparam int DET_W    = 2 * (COORD_BITS + 1) + 1;
   localparam int PIPE_LAT = FRONT_STAGES + ROOT_W + CLASS_STAGES;

   // Configuration registers.
   logic [TOL_W-1:0]   tolerance_ff;
   logic [FLOOR_W-1:0] scale_floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff   <= {{(TOL_W - 1){1'b0}}, 1'b1};
         scale_floor_ff <= {{(FLOOR_W - 1){1'b0}}, 1'b1};
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TOLERANCE: begin
               tolerance_ff <= csr_write_data[TOL_W-1:0];
            end
            CSR_SCALE_FLOOR: begin
               scale_floor_ff <= csr_write_data[FLOOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The pipeline never blocks a new transaction.
   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   logic [7:0][COORD_BITS-1:0] coord;

   assign coord = {req_second_end_y, req_second_end_x,
                   req_second_start_y, req_second_start_x,
                   req_first_end_y, req_first_end_x,
                   req_first_start_y, req_first_start_x};

   // Front end.
   logic                      front_valid;
   logic [3:0][DET_W-1:0]     front_det;
   logic [3:0][SCALE_W-1:0]   front_scale;
   box_flags_type             front_flags;

   sic_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .SCALE_W    (SCALE_W),
      .DET_W      (DET_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_coord    (coord),
      .tolerance   (tolerance_ff),
      .scale_floor (scale_floor_ff),
      .out_valid   (front_valid),
      .out_det     (front_det),
      .out_scale   (front_scale),
      .out_flags   (front_flags)
   );

   // One square root pipeline per orientation test.
   logic [3:0]              root_valid;
   logic [3:0][ROOT_W-1:0]  root;

   for (genvar k = 0; k < 4; k++) begin : g_root
      sic_isqrt #(
         .VALUE_W (SCALE_W)
      ) u_isqrt (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (front_valid),
         .value     (front_scale[k]),
         .out_valid (root_valid[k]),
         .root      (root[k])
      );
   end

   // Cross products and flags wait alongside the square roots.
   logic [ROOT_W-1:0]     dly_valid_ff;
   logic [3:0][DET_W-1:0] dly_det_ff   [ROOT_W];
   box_flags_type         dly_flags_ff [ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_valid_ff <= '0;
      end else begin
         dly_valid_ff <= {dly_valid_ff[ROOT_W-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      dly_det_ff[0]   <= front_det;
      dly_flags_ff[0] <= front_flags;
      for (int i = 1; i < ROOT_W; i++) begin
         dly_det_ff[i]   <= dly_det_ff[i-1];
         dly_flags_ff[i] <= dly_flags_ff[i-1];
      end
   end

   logic dly_valid;

   assign dly_valid = dly_valid_ff[ROOT_W-1];

   // Back end.
   kind_type kind;

   sic_classify #(
      .DET_W  (DET_W),
      .ROOT_W (ROOT_W)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dly_valid),
      .in_det    (dly_det_ff[ROOT_W-1]),
      .in_root   (root),
      .in_flags  (dly_flags_ff[ROOT_W-1]),
      .tolerance (tolerance_ff),
      .out_valid (rsp_valid),
      .out_kind  (kind)
   );

   assign rsp_crossing_kind = kind;

   // A result leaves at the pipeline latency after its transaction.
   `SIC_ASSERT_IMPLIES(a_result_latency, clock, reset, rsp_valid,
      $past(accept, PIPE_LAT), "result without a transaction at the pipeline latency")
   // The root pipelines stay in step with the delayed cross products.
   `SIC_ASSERT_ALWAYS(a_root_aligned, clock, reset, root_valid == {4{dly_valid}},
      "square root valid out of step with the delay line")

endmodule

// File: test/segment_intersection_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_classifier_tb
// Drives pairs of segments into the classifier and checks every crossing
// class against a hand-given class or a behavioral predictor with its own
// copy of the tolerance and scale floor registers. A short table of
// hand-picked pairs comes first. Random phases follow, each under its own
// register settings and with one of three amounts of sender idling.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_tb import sic_pkg::*;;

   localparam int  CW         = 24;
   localparam int  ITEMS_EACH = 125;
   localparam int  PHASES     = 6;
   localparam int  DRAIN      = 40;
   localparam int  CYCLE_CAP  = 300000;
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

   typedef struct {
      logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } seg_pair_type;

   typedef struct {
      seg_pair_type pair;
      bit           typed;
      kind_type     kind;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic signed [CW-1:0]  req_first_start_x  = '0;
   logic signed [CW-1:0]  req_first_start_y  = '0;
   logic signed [CW-1:0]  req_first_end_x    = '0;
   logic signed [CW-1:0]  req_first_end_y    = '0;
   logic signed [CW-1:0]  req_second_start_x = '0;
   logic signed [CW-1:0]  req_second_start_y = '0;
   logic signed [CW-1:0]  req_second_end_x   = '0;
   logic signed [CW-1:0]  req_second_end_y   = '0;
   logic                  rsp_valid;
   logic [1:0]            rsp_crossing_kind;
   logic                  csr_write_enable = 1'b0;
   logic [0:0]            csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   // Predictor copy of the registers.
   longint        model_tol;
   longint        model_floor;
   kind_type      pending_kinds[$];
   table_row_type directed_rows[$];
   int            fail_count = 0;
   int            cycle_count = 0;
   int            idle_pct = 0;

   segment_intersection_classifier dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_start_x  (req_first_start_x),
      .req_first_start_y  (req_first_start_y),
      .req_first_end_x    (req_first_end_x),
      .req_first_end_y    (req_first_end_y),
      .req_second_start_x (req_second_start_x),
      .req_second_start_y (req_second_start_y),
      .req_second_end_x   (req_second_end_x),
      .req_second_end_y   (req_second_end_y),
      .rsp_valid          (rsp_valid),
      .rsp_crossing_kind  (rsp_crossing_kind),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // Floor of the square root, one result bit per step.
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint dist_sq(longint px, longint py, longint qx, longint qy);
      return (px - qx) * (px - qx) + (py - qy) * (py - qy);
   endfunction

   // Tolerant orientation of c against the line a-b.
   function automatic ori_type side_of(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
      longint det;
      longint spread;
      longint thr;
      det    = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      spread = dist_sq(ax, ay, bx, by) + dist_sq(bx, by, cx, cy) +
               dist_sq(cx, cy, ax, ay) + model_floor;
      thr    = model_tol * longint'(floor_sqrt(spread));
      if (det > thr) return ORI_CCW;
      if (det < -thr) return ORI_CW;
      return ORI_COL;
   endfunction

   function automatic bit in_tol_box(longint ax, longint ay, longint bx, longint by,
                                     longint px, longint py);
      longint lox, hix, loy, hiy;
      lox = (ax < bx) ? ax : bx;
      hix = (ax > bx) ? ax : bx;
      loy = (ay < by) ? ay : by;
      hiy = (ay > by) ? ay : by;
      return px >= lox - model_tol && px <= hix + model_tol &&
             py >= loy - model_tol && py <= hiy + model_tol;
   endfunction

   function automatic bit is_point(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = ax - bx;
      dy = ay - by;
      return dx <= model_tol && -dx <= model_tol && dy <= model_tol && -dy <= model_tol;
   endfunction

   function automatic longint lo2(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint hi2(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   // Crossing class of one pair of segments.
   function automatic kind_type classify_pair(seg_pair_type s);
      longint  x1, y1, x2, y2, x3, y3, x4, y4;
      ori_type d1, d2, d3, d4;
      bit      g1, g2;
      x1 = s.ax0; y1 = s.ay0; x2 = s.ax1; y2 = s.ay1;
      x3 = s.bx0; y3 = s.by0; x4 = s.bx1; y4 = s.by1;
      d1 = side_of(x1, y1, x2, y2, x3, y3);
      d2 = side_of(x1, y1, x2, y2, x4, y4);
      d3 = side_of(x3, y3, x4, y4, x1, y1);
      d4 = side_of(x3, y3, x4, y4, x2, y2);
      if (d1 != d2 && d3 != d4 && d1 != ORI_COL && d2 != ORI_COL &&
          d3 != ORI_COL && d4 != ORI_COL)
         return KIND_PROPER;
      if (d1 == ORI_COL && d2 == ORI_COL && d3 == ORI_COL && d4 == ORI_COL) begin
         g1 = is_point(x1, y1, x2, y2);
         g2 = is_point(x3, y3, x4, y4);
         if (g1 || g2) begin
            if (g1 && in_tol_box(x3, y3, x4, y4, x1, y1)) return KIND_TOUCH;
            if (g2 && in_tol_box(x1, y1, x2, y2, x3, y3)) return KIND_TOUCH;
            return KIND_NONE;
         end
         if (lo2(x1, x2) <= hi2(x3, x4) + model_tol &&
             lo2(x3, x4) <= hi2(x1, x2) + model_tol &&
             lo2(y1, y2) <= hi2(y3, y4) + model_tol &&
             lo2(y3, y4) <= hi2(y1, y2) + model_tol)
            return KIND_OVERLAP;
         return KIND_NONE;
      end
      if (d1 == ORI_COL && in_tol_box(x1, y1, x2, y2, x3, y3)) return KIND_TOUCH;
      if (d2 == ORI_COL && in_tol_box(x1, y1, x2, y2, x4, y4)) return KIND_TOUCH;
      if (d3 == ORI_COL && in_tol_box(x3, y3, x4, y4, x1, y1)) return KIND_TOUCH;
      if (d4 == ORI_COL && in_tol_box(x3, y3, x4, y4, x2, y2)) return KIND_TOUCH;
      return KIND_NONE;
   endfunction

   function automatic seg_pair_type make_pair(int a0, int a1, int a2, int a3,
                                              int b0, int b1, int b2, int b3);
      seg_pair_type s;
      s.ax0 = a0; s.ay0 = a1; s.ax1 = a2; s.ay1 = a3;
      s.bx0 = b0; s.by0 = b1; s.bx1 = b2; s.by1 = b3;
      return s;
   endfunction

   function automatic void add_row(seg_pair_type s, bit typed, kind_type k);
      table_row_type r;
      r.pair  = s;
      r.typed = typed;
      r.kind  = k;
      directed_rows.push_back(r);
   endfunction

   function automatic logic signed [CW-1:0] rand_coord(int span);
      return CW'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic logic signed [CW-1:0] edge_coord();
      case ($urandom_range(0, 5))
         0: return CMIN;
         1: return CMAX;
         2: return '0;
         3: return '1;
         4: return CW'(1);
         default: return CW'($urandom);
      endcase
   endfunction

   // Random pair, mostly shaped to land near the interesting classes.
   function automatic seg_pair_type random_pair();
      seg_pair_type s;
      int           bx, by, dx, dy, ka, kb, kc, kd, sp;
      sp = ($urandom_range(0, 3) == 0) ? 200000 : 4096;
      s.ax0 = rand_coord(sp); s.ay0 = rand_coord(sp);
      s.ax1 = rand_coord(sp); s.ay1 = rand_coord(sp);
      s.bx0 = rand_coord(sp); s.by0 = rand_coord(sp);
      s.bx1 = rand_coord(sp); s.by1 = rand_coord(sp);
      case ($urandom_range(0, 6))
         0: begin
            s.ax0 = CW'($urandom); s.ay0 = CW'($urandom);
            s.ax1 = CW'($urandom); s.ay1 = CW'($urandom);
            s.bx0 = CW'($urandom); s.by0 = CW'($urandom);
            s.bx1 = CW'($urandom); s.by1 = CW'($urandom);
         end
         1: begin
            // All four points on one line.
            bx = rand_coord(100000); by = rand_coord(100000);
            dx = $urandom_range(0, 600) - 300; dy = $urandom_range(0, 600) - 300;
            ka = $urandom_range(0, 16) - 8; kb = $urandom_range(0, 16) - 8;
            kc = $urandom_range(0, 16) - 8; kd = $urandom_range(0, 16) - 8;
            s.ax0 = bx + ka * dx; s.ay0 = by + ka * dy;
            s.ax1 = bx + kb * dx; s.ay1 = by + kb * dy;
            s.bx0 = bx + kc * dx; s.by0 = by + kc * dy;
            s.bx1 = bx + kd * dx; s.by1 = by + kd * dy;
         end
         2: begin
            // Shared or nearly shared endpoint.
            if ($urandom_range(0, 1)) begin
               s.bx0 = s.ax0 + rand_coord(2); s.by0 = s.ay0 + rand_coord(2);
            end else begin
               s.bx1 = s.ax1 + rand_coord(2); s.by1 = s.ay1 + rand_coord(2);
            end
         end
         3: begin
            // A degenerate segment somewhere near the other one.
            s.ax1 = s.ax0 + rand_coord(2); s.ay1 = s.ay0 + rand_coord(2);
            if ($urandom_range(0, 1)) begin
               s.bx0 = s.ax0 + rand_coord(4); s.by0 = s.ay0 + rand_coord(4);
            end
            if ($urandom_range(0, 1)) begin
               s.bx1 = s.bx0 + rand_coord(1); s.by1 = s.by0 + rand_coord(1);
            end
         end
         4: begin
            // Endpoint placed on the other segment, at one of its ends or in its interior.
            ka = $urandom_range(0, 8);
            s.ax0 = 8 * rand_coord(512); s.ay0 = 8 * rand_coord(512);
            s.ax1 = s.ax0 + 8 * rand_coord(512); s.ay1 = s.ay0 + 8 * rand_coord(512);
            s.bx0 = s.ax0 + ((s.ax1 - s.ax0) / 8) * ka;
            s.by0 = s.ay0 + ((s.ay1 - s.ay0) / 8) * ka;
         end
         5: begin
            s.ax0 = edge_coord(); s.ay0 = edge_coord();
            s.ax1 = edge_coord(); s.ay1 = edge_coord();
            s.bx0 = edge_coord(); s.by0 = edge_coord();
            s.bx1 = edge_coord(); s.by1 = edge_coord();
         end
         default: ;
      endcase
      return s;
   endfunction

   // Configuration write, only issued with the pipeline empty.
   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      while (pending_kinds.size() != 0) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      if (idx == CSR_TOLERANCE) model_tol = longint'(data[TOL_W-1:0]);
      else model_floor = longint'(data[FLOOR_W-1:0]);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // One transaction: each cycle idles with the given chance, then start
   // is held until the transaction is taken.
   task automatic send_pair(seg_pair_type s, bit typed, kind_type k);
      bit taken;
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_first_start_x  = s.ax0; req_first_start_y  = s.ay0;
      req_first_end_x    = s.ax1; req_first_end_y    = s.ay1;
      req_second_start_x = s.bx0; req_second_start_y = s.by0;
      req_second_end_x   = s.bx1; req_second_end_y   = s.by1;
      start = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         taken = !busy;
         @(posedge clock);
         if (taken) pending_kinds.push_back(typed ? k : classify_pair(s));
         @(negedge clock);
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      kind_type want;
      if (!reset && rsp_valid) begin
         if (pending_kinds.size() == 0) begin
            $error("crossing_kind: result with nothing expected, actual %0d",
                   rsp_crossing_kind);
            fail_count++;
         end else begin
            want = pending_kinds.pop_front();
            if (rsp_crossing_kind !== want) begin
               $error("crossing_kind: expected %0d, actual %0d", want, rsp_crossing_kind);
               fail_count++;
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      model_tol   = 1;
      model_floor = 1;

      // Directed pairs at the reset settings (tolerance 1, floor 1).
      add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, KIND_TOUCH);
      add_row(make_pair(0, 0, 256, 256, 0, 256, 256, 0), 1, KIND_PROPER);
      add_row(make_pair(0, 0, 1024, 0, 512, 0, 2048, 0), 1, KIND_OVERLAP);
      add_row(make_pair(0, 0, 256, 0, 1024, 0, 2048, 0), 1, KIND_NONE);
      add_row(make_pair(0, 0, 1024, 0, 512, 0, 512, 1024), 1, KIND_TOUCH);
      add_row(make_pair(0, 0, 256, 0, 0, 1024, 256, 1024), 1, KIND_NONE);
      add_row(make_pair(0, 0, 1024, 0, 1024, 0, 2048, 512), 0, KIND_NONE);
      add_row(make_pair(0, 0, 1024, 1024, 2048, 0, 1024, 1024), 0, KIND_NONE);
      add_row(make_pair(100, 100, 100, 100, 0, 0, 512, 512), 0, KIND_NONE);
      add_row(make_pair(0, 0, 512, 512, 300, 300, 301, 300), 0, KIND_NONE);
      add_row(make_pair(5, 5, 5, 5, 9000, 9000, 9000, 9000), 1, KIND_NONE);
      add_row(make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN), 0, KIND_NONE);
      add_row(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1, KIND_TOUCH);
      add_row(make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1, KIND_TOUCH);
      add_row(make_pair(CMIN, 0, CMAX, 0, CMIN, 0, CMAX, 0), 1, KIND_OVERLAP);
      add_row(make_pair(CMIN, CMAX, CMAX, CMIN, 0, 0, CMAX, CMAX), 0, KIND_NONE);
      add_row(make_pair(-1, -1, 1, 1, -1, 1, 1, -1), 0, KIND_NONE);
      add_row(make_pair(0, 0, 0, 1, 0, 0, 1, 0), 0, KIND_NONE);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].kind);
      start = 1'b0;

      // Random phases under different register settings and one of three idle rates.
      for (int ph = 0; ph < PHASES; ph++) begin
         start = 1'b0;
         case (ph)
            0: begin
               write_reg(CSR_TOLERANCE, 23'd1);
               write_reg(CSR_SCALE_FLOOR, 23'd1);
            end
            1: begin
               write_reg(CSR_TOLERANCE, 23'd0);
               write_reg(CSR_SCALE_FLOOR, 23'd0);
            end
            2: begin
               write_reg(CSR_TOLERANCE, 23'h7FFFFF);
               write_reg(CSR_SCALE_FLOOR, 23'h7FFFFF);
            end
            3: begin
               write_reg(CSR_TOLERANCE, CSR_DATA_W'($urandom_range(0, 64)));
               write_reg(CSR_SCALE_FLOOR, CSR_DATA_W'($urandom));
            end
            4: begin
               write_reg(CSR_TOLERANCE, CSR_DATA_W'($urandom_range(0, 2048)));
               write_reg(CSR_SCALE_FLOOR, 23'h00FFFF);
            end
            default: begin
               write_reg(CSR_TOLERANCE, 23'd256);
               write_reg(CSR_SCALE_FLOOR, CSR_DATA_W'($urandom) | 23'h7F0000);
            end
         endcase
         idle_pct = (ph < 2) ? 38 : (ph < 4) ? 64 : 0;
         for (int n = 0; n < ITEMS_EACH; n++) begin
            // Once, let the pipeline run dry before going on.
            if (ph == 0 && n == 60) begin
               start = 1'b0;
               while (pending_kinds.size() != 0) @(negedge clock);
            end
            send_pair(random_pair(), 0, KIND_NONE);
         end
      end
      start = 1'b0;

      while (pending_kinds.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && pending_kinds.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/sic_pkg.sv
sv/sic_front.sv
sv/sic_isqrt.sv
sv/sic_classify.sv
sv/segment_intersection_classifier.sv
test/segment_intersection_classifier_tb.sv
